// ===== rtl/core/crpr_pkg.sv =====
// Package: widths, register indexes and helpers for the palette range remapper.
`timescale 1ns / 1ps

package crpr_pkg;

  localparam int ChanW   = 8;
  localparam int RgbW    = 24;
  localparam int NumCh   = 3;
  localparam int NumW    = 16;        // blend numerator, always below 2^16
  localparam int CntW    = 4;         // counts NumW division steps
  localparam int CfgIdxW = 2;

  // floor(s/3) for s <= 765 as (s * 683) >> 11
  localparam int SumW      = 10;
  localparam int MeanMul   = 683;
  localparam int MeanMulW  = 10;
  localparam int MeanShift = 11;
  localparam int MeanProdW = SumW + MeanMulW;

  localparam logic [ChanW-1:0] ChanMax   = 8'hFF;
  localparam logic [RgbW-1:0]  RgbAllOne = 24'hFF_FFFF;

  typedef enum logic [CfgIdxW-1:0] {
    CFG_MID = 2'd0,
    CFG_MAX = 2'd1,
    CFG_MIN = 2'd2,
    CFG_NONE = 2'd3
  } cfg_idx_e;

  typedef logic [ChanW-1:0] chan_t;
  typedef logic [RgbW-1:0]  rgb_t;

  // Byte k of a packed color, red is lane 0
  function automatic chan_t get_chan(input rgb_t rgb, input logic [1:0] lane);
    chan_t c;
    case (lane)
      2'd0:    c = rgb[23:16];
      2'd1:    c = rgb[15:8];
      default: c = rgb[7:0];
    endcase
    return c;
  endfunction

  // Saturate a quotient to one channel
  function automatic chan_t clamp8(input logic [NumW-1:0] q);
    return (|q[NumW-1:ChanW]) ? ChanMax : q[ChanW-1:0];
  endfunction

endpackage

// ===== rtl/core/crpr_if.sv =====
// Channel interfaces: source colors in, key/mapped color pairs out.
`timescale 1ns / 1ps

interface crpr_in_if;
  logic                 valid;
  logic                 ready;
  crpr_pkg::rgb_t       src_color;
  logic                 first_of_palette;

  modport source (output valid, output src_color, output first_of_palette, input ready);
  modport sink   (input valid, input src_color, input first_of_palette, output ready);
endinterface

interface crpr_out_if;
  logic                 valid;
  logic                 ready;
  crpr_pkg::rgb_t       key_color;
  crpr_pkg::rgb_t       mapped_color;

  modport source (output valid, output key_color, output mapped_color, input ready);
  modport sink   (input valid, input key_color, input mapped_color, output ready);
endinterface

// ===== rtl/core/color_range_palette_remap.sv =====
// Top level: palette color range remapper with a bit-serial three-lane divider.
//
//  channel | dir | handshake     | payload
//  --------+-----+---------------+-------------------------------------------
//  src_i   | in  | valid/ready   | src_color[23:0], first_of_palette
//  dst_o   | out | valid/ready   | key_color[23:0], mapped_color[23:0]
//  cfg     | in  | cfg_we_i      | cfg_idx_i[1:0], cfg_data_i[23:0]
//
// Each item passes the channel mean, the blend numerators, the restoring divider
// (one quotient bit per cycle, three lanes sharing one divisor) and the output load.
// The result register frees the core, so the next item is accepted while a
// result waits; while a stalled result holds the output register, a finished item
// keeps done set in the core and no new item is accepted.
// Reset clears control, the reference mean and the mid and min colors, and sets max to all ones.
`timescale 1ns / 1ps

module color_range_palette_remap (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         cfg_we_i,
  input  logic [crpr_pkg::CfgIdxW-1:0] cfg_idx_i,
  input  crpr_pkg::rgb_t               cfg_data_i,
  crpr_in_if.sink                      src_i,
  crpr_out_if.source                   dst_o
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_MEAN = 2'd1;
  localparam logic [1:0] S_NUM  = 2'd2;
  localparam logic [1:0] S_DIV  = 2'd3;

  localparam logic [crpr_pkg::CntW-1:0] CntLast = crpr_pkg::CntW'(crpr_pkg::NumW - 1);

  logic [1:0] state_q, state_d;
  logic [crpr_pkg::CntW-1:0] cnt_q, cnt_d;
  logic       done_q, done_d;   // divider finished, waiting for output slot

  crpr_pkg::rgb_t  mid_q, max_q, min_q;
  crpr_pkg::chan_t ref_q, ref_d;
  crpr_pkg::rgb_t  src_q;
  logic            first_q;
  crpr_pkg::chan_t a_q;
  crpr_pkg::chan_t div_q;
  logic            zero_q;
  logic [crpr_pkg::NumW-1:0]  num_q [crpr_pkg::NumCh];
  logic [crpr_pkg::NumW-1:0]  num_d [crpr_pkg::NumCh];
  logic [crpr_pkg::ChanW-1:0] rem_q [crpr_pkg::NumCh];
  logic [crpr_pkg::ChanW-1:0] rem_d [crpr_pkg::NumCh];

  logic           out_valid_q;
  crpr_pkg::rgb_t key_q, mapped_q, mapped_d;

  logic accept, load_out;

  // Channel mean of the source color
  logic [crpr_pkg::SumW-1:0]      sum;
  logic [crpr_pkg::MeanProdW-1:0] mean_prod;
  crpr_pkg::chan_t                mean;

  assign sum = crpr_pkg::SumW'(src_q[23:16]) + crpr_pkg::SumW'(src_q[15:8])
             + crpr_pkg::SumW'(src_q[7:0]);
  assign mean_prod = crpr_pkg::MeanProdW'(sum)
                   * crpr_pkg::MeanProdW'(crpr_pkg::MeanMul);
  assign mean = mean_prod[crpr_pkg::MeanShift +: crpr_pkg::ChanW];

  assign accept   = src_i.valid && src_i.ready;
  assign load_out = done_q && (!out_valid_q || dst_o.ready);

  assign src_i.ready = (state_q == S_IDLE) && !done_q;

  // Blend setup: pick formula, weights and the shared divisor
  logic            use_lo, use_hi;
  crpr_pkg::chan_t wa, wb, dv;
  crpr_pkg::rgb_t  cb;
  logic [crpr_pkg::NumW-1:0] num_init [crpr_pkg::NumCh];

  always_comb begin
    use_lo = (ref_q != '0) && (a_q <= ref_q);
    use_hi = (ref_q != crpr_pkg::ChanMax) && (a_q >= ref_q);
    if (use_lo) begin
      wa = a_q;
      wb = ref_q - a_q;
      cb = min_q;
      dv = ref_q;
    end else begin
      wa = crpr_pkg::ChanMax - a_q;
      wb = a_q - ref_q;
      cb = max_q;
      dv = crpr_pkg::ChanMax - ref_q;
    end
    for (int k = 0; k < crpr_pkg::NumCh; k++) begin
      num_init[k] = crpr_pkg::NumW'(wa) * crpr_pkg::NumW'(crpr_pkg::get_chan(mid_q, 2'(k)))
                  + crpr_pkg::NumW'(wb) * crpr_pkg::NumW'(crpr_pkg::get_chan(cb, 2'(k)));
    end
  end

  // One restoring-division step per lane
  logic [crpr_pkg::ChanW:0] trial [crpr_pkg::NumCh];
  logic [crpr_pkg::ChanW:0] diff  [crpr_pkg::NumCh];
  logic                     ge    [crpr_pkg::NumCh];

  always_comb begin
    for (int k = 0; k < crpr_pkg::NumCh; k++) begin
      trial[k] = {rem_q[k], num_q[k][crpr_pkg::NumW-1]};
      diff[k]  = trial[k] - {1'b0, div_q};
      ge[k]    = trial[k] >= {1'b0, div_q};
    end
  end

  // Sequencer
  always_comb begin
    state_d = state_q;
    cnt_d   = cnt_q;
    done_d  = done_q;
    ref_d   = ref_q;
    for (int k = 0; k < crpr_pkg::NumCh; k++) begin
      num_d[k] = num_q[k];
      rem_d[k] = rem_q[k];
    end
    case (state_q)
      S_IDLE: begin
        if (accept) state_d = S_MEAN;
        if (load_out) done_d = 1'b0;
      end
      S_MEAN: begin
        if (first_q) ref_d = mean;
        state_d = S_NUM;
      end
      S_NUM: begin
        for (int k = 0; k < crpr_pkg::NumCh; k++) begin
          num_d[k] = num_init[k];
          rem_d[k] = '0;
        end
        cnt_d   = '0;
        state_d = S_DIV;
      end
      S_DIV: begin
        for (int k = 0; k < crpr_pkg::NumCh; k++) begin
          num_d[k] = {num_q[k][crpr_pkg::NumW-2:0], ge[k]};
          rem_d[k] = ge[k] ? diff[k][crpr_pkg::ChanW-1:0] : trial[k][crpr_pkg::ChanW-1:0];
        end
        cnt_d = cnt_q + 1'b1;
        if (cnt_q == CntLast) begin
          done_d  = 1'b1;
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      cnt_q   <= '0;
      done_q  <= 1'b0;
      ref_q   <= '0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      done_q  <= done_d;
      ref_q   <= ref_d;
    end
  end

  // Datapath registers
  always_ff @(posedge clk_i) begin
    if (accept) begin
      src_q   <= src_i.src_color;
      first_q <= src_i.first_of_palette;
    end
    if (state_q == S_MEAN) a_q <= mean;
    if (state_q == S_NUM) begin
      div_q  <= dv;
      zero_q <= !use_lo && !use_hi;
    end
    for (int k = 0; k < crpr_pkg::NumCh; k++) begin
      num_q[k] <= num_d[k];
      rem_q[k] <= rem_d[k];
    end
  end

  // Configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mid_q <= '0;
      max_q <= crpr_pkg::RgbAllOne;
      min_q <= '0;
    end else if (cfg_we_i) begin
      case (crpr_pkg::cfg_idx_e'(cfg_idx_i))
        crpr_pkg::CFG_MID: mid_q <= cfg_data_i;
        crpr_pkg::CFG_MAX: max_q <= cfg_data_i;
        crpr_pkg::CFG_MIN: min_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Output register
  always_comb begin
    for (int k = 0; k < crpr_pkg::NumCh; k++) begin
      mapped_d[crpr_pkg::RgbW-1-crpr_pkg::ChanW*k -: crpr_pkg::ChanW] =
        zero_q ? '0 : crpr_pkg::clamp8(num_q[k]);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (load_out) begin
      out_valid_q <= 1'b1;
    end else if (dst_o.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_out) begin
      key_q    <= src_q;
      mapped_q <= mapped_d;
    end
  end

  assign dst_o.valid        = out_valid_q;
  assign dst_o.key_color    = key_q;
  assign dst_o.mapped_color = mapped_q;

  // Checks
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == S_MEAN))
    else $error("accepted item did not start the mean step");

  a_div_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_DIV) && (cnt_q == CntLast) |=> done_q && (state_q == S_IDLE))
    else $error("divider did not finish after its last step");

  a_zero_case: assert property (@(posedge clk_i) disable iff (!rst_ni)
    load_out && zero_q |=> dst_o.valid && (dst_o.mapped_color == '0))
    else $error("degenerate reference did not give a zero color");

endmodule

// ===== tb/tb.sv =====
// Testbench for the palette color range remapper: predicted remap checked per result item.
`timescale 1ns / 1ps

module tb;

  localparam int LimitCycles = 400000;
  localparam int LongHold    = 300;   // receiver hold-off, well past the core depth
  localparam int TailCycles  = 40;    // idle tail before the final report
  localparam int PhaseItems  = 250;

  typedef struct packed {
    crpr_pkg::rgb_t key;
    crpr_pkg::rgb_t mapped;
  } color_pair_t;

  logic clk_i;
  logic rst_ni;
  logic cfg_we_i;
  logic [crpr_pkg::CfgIdxW-1:0] cfg_idx_i;
  crpr_pkg::rgb_t cfg_data_i;

  crpr_in_if  src_bus ();
  crpr_out_if dst_bus ();

  color_range_palette_remap u_top (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_idx_i  (cfg_idx_i),
    .cfg_data_i (cfg_data_i),
    .src_i      (src_bus),
    .dst_o      (dst_bus)
  );

  // Predictor state: color registers and the palette reference brightness
  crpr_pkg::rgb_t  mid_reg = '0;
  crpr_pkg::rgb_t  max_reg = crpr_pkg::RgbAllOne;
  crpr_pkg::rgb_t  min_reg = '0;
  crpr_pkg::chan_t ref_mean = '0;
  crpr_pkg::rgb_t  pal_ref = '0;

  color_pair_t pending_pairs[$];

  int  cycle_cnt = 0;
  int  mismatches = 0;
  int  colors_in = 0;
  int  pairs_checked = 0;
  int  palettes_started = 0;
  int  settings_used = 1;
  bit  quiet = 1'b0;
  bit  hold_long = 1'b0;

  // Clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  always @(posedge clk_i) cycle_cnt <= cycle_cnt + 1;

  // One output channel, integer blend toward mid from min or max
  function automatic crpr_pkg::chan_t blend_chan(int a, int r, crpr_pkg::chan_t m,
                                                 crpr_pkg::chan_t mn, crpr_pkg::chan_t mx);
    int num;
    int den;
    int q;
    if (r != 0 && a <= r) begin
      num = a * m + (r - a) * mn;
      den = r;
    end else if (r != int'(crpr_pkg::ChanMax) && a >= r) begin
      num = (int'(crpr_pkg::ChanMax) - a) * m + (a - r) * mx;
      den = int'(crpr_pkg::ChanMax) - r;
    end else begin
      return '0;
    end
    q = num / den;
    return (q > int'(crpr_pkg::ChanMax)) ? crpr_pkg::ChanMax : crpr_pkg::chan_t'(q);
  endfunction

  // Key/mapped pair for one accepted color; a palette start loads the reference first
  function automatic color_pair_t remap_color(crpr_pkg::rgb_t src, logic first);
    color_pair_t res;
    int a;
    int r;
    a = (int'(src[23:16]) + int'(src[15:8]) + int'(src[7:0])) / 3;
    if (first) ref_mean = crpr_pkg::chan_t'(a);
    r = int'(ref_mean);
    res.key = src;
    for (int k = 0; k < crpr_pkg::NumCh; k++) begin
      res.mapped[8*k +: 8] = blend_chan(a, r, mid_reg[8*k +: 8], min_reg[8*k +: 8],
                                        max_reg[8*k +: 8]);
    end
    return res;
  endfunction

  task automatic flag_mismatch(string what, crpr_pkg::rgb_t want, crpr_pkg::rgb_t got);
    mismatches++;
    if (mismatches <= 10)
      $display("[%0t] %s mismatch: expected %06h, got %06h", $realtime, what, want, got);
  endtask

  // Input monitor: predict on every accepted color
  always @(posedge clk_i) begin
    if (rst_ni && src_bus.valid && src_bus.ready) begin
      pending_pairs.push_back(remap_color(src_bus.src_color, src_bus.first_of_palette));
      colors_in++;
      if (src_bus.first_of_palette) palettes_started++;
    end
  end

  // Output checker: oldest expectation against each accepted result
  always @(posedge clk_i) begin
    color_pair_t want;
    if (rst_ni && dst_bus.valid && dst_bus.ready) begin
      pairs_checked++;
      if (pending_pairs.size() == 0) begin
        flag_mismatch("unexpected result, key", '0, dst_bus.key_color);
      end else begin
        want = pending_pairs.pop_front();
        if (dst_bus.key_color !== want.key)
          flag_mismatch("key_color", want.key, dst_bus.key_color);
        if (dst_bus.mapped_color !== want.mapped)
          flag_mismatch($sformatf("mapped_color (key %06h)", want.key), want.mapped,
                        dst_bus.mapped_color);
      end
    end
  end

  // Receiver: random ready bursts, or one long hold-off on request
  initial begin
    dst_bus.ready <= 1'b0;
    @(posedge clk_i);
    forever begin
      if (hold_long) begin
        dst_bus.ready <= 1'b0;
        repeat (LongHold) @(posedge clk_i);
        hold_long = 1'b0;
      end else if (!quiet && $urandom_range(0, 3) == 0) begin
        dst_bus.ready <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk_i);
      end else begin
        dst_bus.ready <= 1'b1;
        repeat ($urandom_range(1, 12)) @(posedge clk_i);
      end
    end
  end

  // Watchdog
  initial begin
    while (cycle_cnt < LimitCycles) @(posedge clk_i);
    $display("Verification failed");
    $finish;
  end

  // Offer one color and wait until it is accepted; valid stays up for a follow-on item
  task automatic send_color(crpr_pkg::rgb_t color, logic first);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      src_bus.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    src_bus.valid            <= 1'b1;
    src_bus.src_color        <= color;
    src_bus.first_of_palette <= first;
    do @(posedge clk_i); while (!src_bus.ready);
  endtask

  // Stop offering and wait for every outstanding mapped color
  task automatic wait_all_mapped();
    src_bus.valid <= 1'b0;
    @(posedge clk_i);
    while (pending_pairs.size() != 0) @(posedge clk_i);
  endtask

  // Write mid, max and min, plus one write to the unused index that must be ignored
  task automatic load_colors(crpr_pkg::rgb_t mid, crpr_pkg::rgb_t mx, crpr_pkg::rgb_t mn);
    crpr_pkg::cfg_idx_e idx_list[4];
    crpr_pkg::rgb_t     val_list[4];
    idx_list = '{crpr_pkg::CFG_MID, crpr_pkg::CFG_MAX, crpr_pkg::CFG_MIN, crpr_pkg::CFG_NONE};
    val_list = '{mid, mx, mn, crpr_pkg::rgb_t'($urandom())};
    for (int i = 0; i < 4; i++) begin
      cfg_we_i   <= 1'b1;
      cfg_idx_i  <= idx_list[i];
      cfg_data_i <= val_list[i];
      case (idx_list[i])
        crpr_pkg::CFG_MID: mid_reg = val_list[i];
        crpr_pkg::CFG_MAX: max_reg = val_list[i];
        crpr_pkg::CFG_MIN: min_reg = val_list[i];
        default: ;
      endcase
      @(posedge clk_i);
    end
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  function automatic crpr_pkg::rgb_t rand_cfg();
    case ($urandom_range(0, 4))
      0:       return '0;
      1:       return crpr_pkg::RgbAllOne;
      2:       return {{8{1'($urandom_range(0, 1))}}, {8{1'($urandom_range(0, 1))}},
                       {8{1'($urandom_range(0, 1))}}};
      default: return crpr_pkg::rgb_t'($urandom());
    endcase
  endfunction

  // Mix of plain random, near-grey, saturated and near-reference colors
  function automatic crpr_pkg::rgb_t rand_color();
    crpr_pkg::chan_t g;
    g = crpr_pkg::chan_t'($urandom_range(0, 255));
    case ($urandom_range(0, 5))
      0, 1:    return crpr_pkg::rgb_t'($urandom());
      2:       return {g + crpr_pkg::chan_t'($urandom_range(0, 2)), g,
                       g - crpr_pkg::chan_t'($urandom_range(0, 2))};
      3:       return {{8{1'($urandom_range(0, 1))}}, {8{1'($urandom_range(0, 1))}},
                       {8{1'($urandom_range(0, 1))}}};
      default: return pal_ref ^ crpr_pkg::rgb_t'($urandom_range(0, 3)
                                                 << (8 * $urandom_range(0, 2)));
    endcase
  endfunction

  // Palettes with random content, some loose colors with a random start flag
  task automatic run_palettes(int n_items);
    int left;
    int len;
    left = n_items;
    while (left > 0) begin
      if ($urandom_range(0, 9) == 0) begin
        send_color(rand_color(), 1'($urandom_range(0, 1)));
        left--;
      end else begin
        len = $urandom_range(1, 16);
        pal_ref = rand_color();
        send_color(pal_ref, 1'b1);
        left--;
        for (int i = 1; i < len && left > 0; i++) begin
          send_color(rand_color(), 1'b0);
          left--;
        end
      end
      // sender pause halfway through a phase
      if (left > n_items / 2 - 8 && left <= n_items / 2) begin
        wait_all_mapped();
        left = left - 1 + 1;
      end
    end
    wait_all_mapped();
  endtask

  // Reset register values, no palette started: reference stays zero
  task automatic test_no_palette_yet();
    send_color(24'h000000, 1'b0);
    send_color(24'hFFFFFF, 1'b0);
    send_color(24'h808080, 1'b0);
    send_color(24'h123456, 1'b0);
    wait_all_mapped();
  endtask

  // Reference at full, zero and mid brightness; reference color and equal-mean colors
  task automatic test_reference_extremes();
    load_colors(24'h4080C0, 24'hFFFFFF, 24'h000000);
    send_color(24'hFFFFFF, 1'b1);
    send_color(24'h000000, 1'b0);
    send_color(24'h7F7F7F, 1'b0);
    send_color(24'hFEFFFE, 1'b0);
    send_color(24'h000000, 1'b1);
    send_color(24'hFFFFFF, 1'b0);
    send_color(24'h808080, 1'b0);
    send_color(24'h102030, 1'b1);
    send_color(24'h201020, 1'b0);
    send_color(24'h302010, 1'b0);
    send_color(24'h000000, 1'b0);
    send_color(24'hFFFFFF, 1'b0);
    wait_all_mapped();
    load_colors(24'hFFFFFF, 24'h000000, 24'hFFFFFF);
    send_color(24'h808080, 1'b1);
    send_color(24'h000000, 1'b0);
    send_color(24'hFFFFFF, 1'b0);
    send_color(24'h808080, 1'b0);
    wait_all_mapped();
    load_colors(24'h000000, 24'h000000, 24'h000000);
    send_color(24'hFF00FF, 1'b1);
    send_color(24'h00FF00, 1'b0);
    wait_all_mapped();
  endtask

  // Receiver holds off while the sender keeps offering, so the input stalls
  task automatic test_backpressure();
    load_colors(rand_cfg(), rand_cfg(), rand_cfg());
    hold_long = 1'b1;
    pal_ref = rand_color();
    send_color(pal_ref, 1'b1);
    for (int i = 0; i < 11; i++) send_color(rand_color(), 1'b0);
    wait_all_mapped();
  endtask

  task automatic test_random_settings(int n_phases);
    for (int p = 0; p < n_phases; p++) begin
      load_colors(rand_cfg(), rand_cfg(), rand_cfg());
      run_palettes(PhaseItems);
    end
  endtask

  // Last phase with no idling on either side
  task automatic test_full_rate();
    quiet = 1'b1;
    load_colors(rand_cfg(), rand_cfg(), rand_cfg());
    run_palettes(PhaseItems);
  endtask

  // Main sequence
  initial begin
    rst_ni                   <= 1'b0;
    cfg_we_i                 <= 1'b0;
    cfg_idx_i                <= crpr_pkg::CFG_MID;
    cfg_data_i               <= '0;
    src_bus.valid            <= 1'b0;
    src_bus.src_color        <= '0;
    src_bus.first_of_palette <= 1'b0;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_no_palette_yet();
    test_reference_extremes();
    test_backpressure();
    test_random_settings(6);
    test_full_rate();

    repeat (TailCycles) @(posedge clk_i);
    $display("Mapped %0d colors in %0d palettes under %0d register settings,",
             colors_in, palettes_started, settings_used);
    $display("with stalls on both sides and a full-rate tail: %0d results, %0d mismatches.",
             pairs_checked, mismatches);
    if (mismatches == 0 && pending_pairs.size() == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
